// ----- sv/dkds_pkg.sv -----
// Shared types, constants and helpers for debounced_keypad_dac_setpoint.
// No dependencies; every other file of the block imports this package.
package dkds_pkg;

   localparam int unsigned KEY_W      = 4;
   localparam int unsigned CODE_W     = 8;
   localparam int unsigned VREF_W     = 14;
   localparam int unsigned RUN_W      = 4;
   localparam int unsigned QUOT_W     = 7;
   localparam int unsigned MV_W       = 14;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned PROD_W     = QUOT_W + CODE_W;

   // Active-low key line patterns
   localparam logic [KEY_W-1:0] LINES_IDLE = 4'hF;
   localparam logic [KEY_W-1:0] LINES_S1   = 4'hE;
   localparam logic [KEY_W-1:0] LINES_S5   = 4'hD;
   localparam logic [KEY_W-1:0] LINES_K3   = 4'hB;
   localparam logic [KEY_W-1:0] LINES_K4   = 4'h7;

   // Register map (byte address bit 2 selects the register)
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic        REG_VREF     = 1'b0;
   localparam logic        REG_DEBOUNCE = 1'b1;

   localparam int unsigned VREF_RESET_VAL = 4700;
   localparam logic [VREF_W-1:0] VREF_RESET     = VREF_W'(VREF_RESET_VAL);
   localparam logic [RUN_W-1:0]  DEBOUNCE_RESET = 4'd5;

   // x / 255 == ((x + 1) * 257) >> 16 for x below 65535
   localparam int unsigned DIV255_MUL   = 257;
   localparam int unsigned DIV255_SHIFT = 16;
   localparam int unsigned DIV255_PW    = 24;
   localparam logic [QUOT_W-1:0] VREF_QUOT_RESET = QUOT_W'(VREF_RESET_VAL / 255);

   localparam logic [MV_W-1:0]    MV_MAX      = 14'd9999;
   localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'd10;

   typedef enum logic [2:0] {
      KEY_NONE = 3'd0,
      KEY_UP   = 3'd1,
      KEY_DOWN = 3'd2,
      KEY_AUX3 = 3'd3,
      KEY_AUX4 = 3'd4
   } key_code_type;

   typedef struct packed {
      logic [CODE_W-1:0] dac_code;
      logic              dac_write;
      key_code_type      released_key;
   } key_result_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [MV_W-1:0]    rest;
   } digit_split_type;

   typedef struct packed {
      logic [CODE_W-1:0]  dac_code;
      logic               dac_write;
      key_code_type       released_key;
      logic [DIGIT_W-1:0] digit_thousands;
      logic [DIGIT_W-1:0] digit_hundreds;
      logic [DIGIT_W-1:0] digit_tens;
      logic [DIGIT_W-1:0] digit_ones;
   } display_type;

   // Load strobes for the six pipeline registers
   typedef struct packed {
      logic key;
      logic state;
      logic product;
      logic thousands;
      logic hundreds;
      logic result;
   } pipe_load_type;

   // One decimal digit of a value below 10 * base: parallel threshold compares
   function automatic digit_split_type split_digit(input logic [MV_W-1:0] value,
                                                   input logic [MV_W-1:0] base);
      digit_split_type res;
      res.digit = '0;
      for (int k = 1; k <= 9; k++) begin
         if (value >= MV_W'(k * base)) begin
            res.digit = res.digit + DIGIT_W'(1);
         end
      end
      res.rest = value - MV_W'(res.digit * base);
      return res;
   endfunction

endpackage

// ----- sv/debounced_keypad_dac_setpoint.sv -----
// Top level of debounced_keypad_dac_setpoint: pipeline control and ports.
// Depends on dkds_pkg, dkds_csr, dkds_key_ctrl and dkds_digits.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall| req_key_lines
//   rsp     | out       | rsp_valid/rsp_stall| rsp_dac_code, rsp_dac_write,
//           |           |                    | rsp_released_key, rsp_digit_*
//   csr     | in/out    | psel/penable/pready| vref_mv at 0x0, debounce_count at 0x4
//
// One request is taken per cycle while req_stall is low; each then passes the
// state, product, thousands, hundreds and result registers. The key state update
// (debounce counter, latch, setpoint) is a read-modify-write done as a request
// leaves the input register. reset is synchronous and clears all valid bits
// and key state; registers return to vref_mv 4700 and debounce_count 5.
// A stalled result holds while empty stages keep filling behind it.
module debounced_keypad_dac_setpoint
   import dkds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KEY_W-1:0]      req_key_lines,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_W-1:0]     rsp_dac_code,
   output logic                  rsp_dac_write,
   output logic [2:0]            rsp_released_key,
   output logic [DIGIT_W-1:0]    rsp_digit_thousands,
   output logic [DIGIT_W-1:0]    rsp_digit_hundreds,
   output logic [DIGIT_W-1:0]    rsp_digit_tens,
   output logic [DIGIT_W-1:0]    rsp_digit_ones,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Valid bits, one per pipeline register: key, state, product,
   // thousands, hundreds, result
   logic [5:0]        valid_ff, valid_in;
   logic [5:0]        free;
   pipe_load_type     load;
   logic [KEY_W-1:0]  key_lines_ff;
   logic [QUOT_W-1:0] vref_quot;
   logic [RUN_W-1:0]  debounce_count;
   key_result_type    key_result;
   display_type       display;

   // Stage k may load when empty or when its content moves on this cycle
   always_comb begin
      free[5]        = !valid_ff[5] || !rsp_stall;
      load.result    = valid_ff[4] && free[5];
      free[4]        = !valid_ff[4] || load.result;
      load.hundreds  = valid_ff[3] && free[4];
      free[3]        = !valid_ff[3] || load.hundreds;
      load.thousands = valid_ff[2] && free[3];
      free[2]        = !valid_ff[2] || load.thousands;
      load.product   = valid_ff[1] && free[2];
      free[1]        = !valid_ff[1] || load.product;
      load.state     = valid_ff[0] && free[1];
      free[0]        = !valid_ff[0] || load.state;
      load.key       = req_valid && free[0];

      // Set on load, drop when the content moves downstream
      valid_in[0] = load.key       || (valid_ff[0] && !load.state);
      valid_in[1] = load.state     || (valid_ff[1] && !load.product);
      valid_in[2] = load.product   || (valid_ff[2] && !load.thousands);
      valid_in[3] = load.thousands || (valid_ff[3] && !load.hundreds);
      valid_in[4] = load.hundreds  || (valid_ff[4] && !load.result);
      valid_in[5] = load.result    || (valid_ff[5] && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input register: hold the sampled key lines
   always_ff @(posedge clock) begin
      if (load.key) begin
         key_lines_ff <= req_key_lines;
      end
   end

   dkds_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .vref_quot      (vref_quot),
      .debounce_count (debounce_count)
   );

   dkds_key_ctrl u_key_ctrl (
      .clock          (clock),
      .reset          (reset),
      .load           (load.state),
      .key_lines      (key_lines_ff),
      .debounce_count (debounce_count),
      .result         (key_result)
   );

   dkds_digits u_digits (
      .clock      (clock),
      .load       (load),
      .key_result (key_result),
      .vref_quot  (vref_quot),
      .display    (display)
   );

   assign csr_pready = 1'b1;
   assign req_stall  = !free[0];
   assign rsp_valid  = valid_ff[5];

   assign rsp_dac_code        = display.dac_code;
   assign rsp_dac_write       = display.dac_write;
   assign rsp_released_key    = display.released_key;
   assign rsp_digit_thousands = display.digit_thousands;
   assign rsp_digit_hundreds  = display.digit_hundreds;
   assign rsp_digit_tens      = display.digit_tens;
   assign rsp_digit_ones      = display.digit_ones;

endmodule

// ----- sv/dkds_csr.sv -----
// Configuration registers of debounced_keypad_dac_setpoint, APB-style write/read.
// Depends on dkds_pkg. Keeps vref_mv / 255 precomputed on each vref_mv write.
module dkds_csr
   import dkds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic [QUOT_W-1:0]     vref_quot,
   output logic [RUN_W-1:0]      debounce_count
);

   logic [VREF_W-1:0]    vref_ff;
   logic [RUN_W-1:0]     debounce_ff;
   logic [QUOT_W-1:0]    vref_quot_ff;
   logic                 wr_en;
   logic [VREF_W:0]      vref_inc;
   logic [DIV255_PW-1:0] quot_prod;

   assign wr_en     = psel && penable && pwrite;
   assign vref_inc  = (VREF_W+1)'(pwdata[VREF_W-1:0]) + (VREF_W+1)'(1);
   assign quot_prod = DIV255_PW'(vref_inc) * DIV255_PW'(DIV255_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff      <= VREF_RESET;
         debounce_ff  <= DEBOUNCE_RESET;
         vref_quot_ff <= VREF_QUOT_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_VREF) begin
            vref_ff      <= pwdata[VREF_W-1:0];
            vref_quot_ff <= quot_prod[DIV255_SHIFT +: QUOT_W];
         end else begin
            debounce_ff <= pwdata[RUN_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_DEBOUNCE) begin
         prdata = CSR_DATA_W'(debounce_ff);
      end else begin
         prdata = CSR_DATA_W'(vref_ff);
      end
   end

   assign vref_quot      = vref_quot_ff;
   assign debounce_count = debounce_ff;

endmodule

// ----- sv/dkds_key_ctrl.sv -----
// Debounce, key latch, release detect and setpoint update for one sample.
// Depends on dkds_pkg. Result goes to a register loaded with the state.
module dkds_key_ctrl
   import dkds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [KEY_W-1:0]     key_lines,
   input  logic [RUN_W-1:0]     debounce_count,
   output key_result_type       result
);

   logic [RUN_W-1:0]  press_run_ff, press_run_in;
   logic              qualified_ff, qualified_in;
   key_code_type      latched_ff, latched_in;
   logic [CODE_W-1:0] setpoint_ff, setpoint_in;
   key_result_type    result_ff, result_in;

   logic              idle;
   logic              hit;
   logic              qual_mid;
   logic              release_now;
   logic [RUN_W-1:0]  run_inc;
   key_code_type      pressed_code;

   always_comb begin
      case (key_lines)
         LINES_S1: pressed_code = KEY_UP;
         LINES_S5: pressed_code = KEY_DOWN;
         LINES_K3: pressed_code = KEY_AUX3;
         LINES_K4: pressed_code = KEY_AUX4;
         default:  pressed_code = KEY_NONE;
      endcase
   end

   always_comb begin
      idle         = (key_lines == LINES_IDLE);
      run_inc      = idle ? '0 : press_run_ff + RUN_W'(1);
      hit          = (run_inc == debounce_count);
      press_run_in = hit ? '0 : run_inc;
      qual_mid     = qualified_ff || hit;
      latched_in   = (hit && pressed_code != KEY_NONE) ? pressed_code : latched_ff;
      release_now  = qual_mid && idle;
      qualified_in = release_now ? 1'b0 : qual_mid;

      setpoint_in            = setpoint_ff;
      result_in.dac_write    = 1'b0;
      result_in.released_key = release_now ? latched_in : KEY_NONE;
      if (release_now && latched_in == KEY_UP) begin
         setpoint_in         = setpoint_ff + CODE_W'(1);
         result_in.dac_write = 1'b1;
      end else if (release_now && latched_in == KEY_DOWN) begin
         setpoint_in         = setpoint_ff - CODE_W'(1);
         result_in.dac_write = 1'b1;
      end
      result_in.dac_code = setpoint_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_run_ff <= '0;
         qualified_ff <= 1'b0;
         latched_ff   <= KEY_NONE;
         setpoint_ff  <= '0;
      end else if (load) begin
         press_run_ff <= press_run_in;
         qualified_ff <= qualified_in;
         latched_ff   <= latched_in;
         setpoint_ff  <= setpoint_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- sv/dkds_digits.sv -----
// Millivolt product, saturation and decimal digit split, one step per stage.
// Depends on dkds_pkg. Stage loads come from the top-level pipeline control.
module dkds_digits
   import dkds_pkg::*;
(
   input  logic              clock,
   input  pipe_load_type     load,
   input  key_result_type    key_result,
   input  logic [QUOT_W-1:0] vref_quot,
   output display_type       display
);

   key_result_type     key_p_ff, key_t_ff, key_h_ff;
   logic [MV_W-1:0]    mv_ff;
   logic [DIGIT_W-1:0] th_t_ff, th_h_ff, hu_h_ff;
   logic [9:0]         rest_t_ff;
   logic [6:0]         rest_h_ff;
   display_type        display_ff, display_in;

   logic [PROD_W-1:0]  product;
   logic [MV_W-1:0]    mv_in;
   digit_split_type    th_split, hu_split, te_split;

   assign product = PROD_W'(vref_quot) * PROD_W'(key_result.dac_code);
   assign mv_in   = (product > PROD_W'(MV_MAX)) ? MV_MAX : product[MV_W-1:0];

   assign th_split = split_digit(mv_ff, MV_W'(1000));
   assign hu_split = split_digit(MV_W'(rest_t_ff), MV_W'(100));
   assign te_split = split_digit(MV_W'(rest_h_ff), MV_W'(10));

   always_comb begin
      display_in.dac_code     = key_h_ff.dac_code;
      display_in.dac_write    = key_h_ff.dac_write;
      display_in.released_key = key_h_ff.released_key;
      display_in.digit_thousands = (th_h_ff == '0) ? BLANK_DIGIT : th_h_ff;
      display_in.digit_hundreds  = (th_h_ff == '0 && hu_h_ff == '0) ? BLANK_DIGIT : hu_h_ff;
      display_in.digit_tens      = (th_h_ff == '0 && hu_h_ff == '0 && te_split.digit == '0)
                                   ? BLANK_DIGIT : te_split.digit;
      display_in.digit_ones      = te_split.rest[DIGIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load.product) begin
         key_p_ff <= key_result;
         mv_ff    <= mv_in;
      end
      if (load.thousands) begin
         key_t_ff  <= key_p_ff;
         th_t_ff   <= th_split.digit;
         rest_t_ff <= th_split.rest[9:0];
      end
      if (load.hundreds) begin
         key_h_ff  <= key_t_ff;
         th_h_ff   <= th_t_ff;
         hu_h_ff   <= hu_split.digit;
         rest_h_ff <= hu_split.rest[6:0];
      end
      if (load.result) begin
         display_ff <= display_in;
      end
   end

   assign display = display_ff;

endmodule

// ----- sv/dkds_checker.sv -----
// Port-level checks for debounced_keypad_dac_setpoint, bound to the top level.
// Depends on dkds_pkg.
module dkds_checker
   import dkds_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [CODE_W-1:0]     rsp_dac_code,
   input logic                  rsp_dac_write,
   input logic [2:0]            rsp_released_key,
   input logic [DIGIT_W-1:0]    rsp_digit_thousands,
   input logic [DIGIT_W-1:0]    rsp_digit_hundreds,
   input logic [DIGIT_W-1:0]    rsp_digit_tens
);

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dac_code))
      else $error("stalled result dropped or changed");

   // A DAC write only comes from releasing up or down
   a_write_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dac_write |->
         (rsp_released_key == 3'(KEY_UP) || rsp_released_key == 3'(KEY_DOWN)))
      else $error("dac write without up or down release");

   // Blanking only removes leading zeros
   a_blank_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_tens == BLANK_DIGIT |->
         rsp_digit_hundreds == BLANK_DIGIT && rsp_digit_thousands == BLANK_DIGIT)
      else $error("blank digit after a shown digit");

endmodule

bind debounced_keypad_dac_setpoint dkds_checker u_dkds_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_dac_code        (rsp_dac_code),
   .rsp_dac_write       (rsp_dac_write),
   .rsp_released_key    (rsp_released_key),
   .rsp_digit_thousands (rsp_digit_thousands),
   .rsp_digit_hundreds  (rsp_digit_hundreds),
   .rsp_digit_tens      (rsp_digit_tens)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for debounced_keypad_dac_setpoint: key samples in, DAC code and
// millivolt digits out, checked against a cycle-free predictor. Depends on dkds_pkg and the RTL.
module testbench;
   import dkds_pkg::*;

   localparam int unsigned CODE_FULL_SCALE = 255;
   localparam int unsigned VREF_MAX        = (1 << VREF_W) - 1;
   localparam int unsigned LONG_HOLD       = 60;
   localparam int unsigned DRAIN_CYCLES    = 10;
   localparam int unsigned PHASE_ITEMS     = 55;
   localparam int unsigned RANDOM_PHASES   = 10;
   // Patterns that press more than one key at once
   localparam logic [KEY_W-1:0] LINES_ALL_DOWN = 4'h0;
   localparam logic [KEY_W-1:0] LINES_TWO_KEYS = 4'h5;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KEY_W-1:0]      req_key_lines = LINES_IDLE;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_dac_code;
   logic                  rsp_dac_write;
   logic [2:0]            rsp_released_key;
   logic [DIGIT_W-1:0]    rsp_digit_thousands;
   logic [DIGIT_W-1:0]    rsp_digit_hundreds;
   logic [DIGIT_W-1:0]    rsp_digit_tens;
   logic [DIGIT_W-1:0]    rsp_digit_ones;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor copy of the configuration and key state, at reset values
   logic [VREF_W-1:0]     vref_cfg      = VREF_RESET;
   logic [RUN_W-1:0]      debounce_cfg  = DEBOUNCE_RESET;
   logic [RUN_W-1:0]      run_count     = '0;
   logic                  key_armed     = 1'b0;
   key_code_type          held_key      = KEY_NONE;
   logic [CODE_W-1:0]     setpoint_code = '0;

   logic [KEY_W-1:0]      pending_lines[$];   // samples not yet offered
   display_type           expected_q[$];      // predicted results, oldest first
   int unsigned           pushed_items = 0;
   int unsigned           fail_count   = 0;

   // Handshake bookkeeping shared by driver, receiver and monitor
   logic                  req_taken   = 1'b0;
   logic                  rsp_taken   = 1'b0;
   logic                  gaps_on     = 1'b1;
   int unsigned           req_gap     = 0;
   int unsigned           rsp_gap     = 0;
   int unsigned           hold_left   = 0;
   int unsigned           hold_asked  = 0;
   int unsigned           hold_served = 0;

   debounced_keypad_dac_setpoint uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_key_lines       (req_key_lines),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_dac_code        (rsp_dac_code),
      .rsp_dac_write       (rsp_dac_write),
      .rsp_released_key    (rsp_released_key),
      .rsp_digit_thousands (rsp_digit_thousands),
      .rsp_digit_hundreds  (rsp_digit_hundreds),
      .rsp_digit_tens      (rsp_digit_tens),
      .rsp_digit_ones      (rsp_digit_ones),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // 10 ns clock: rising edges at 5, 15, 25 ...
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the key state by one sample and return what the block must show.
   // Count pressed samples, qualify on an exact match with the threshold, latch only
   // single-key patterns, and act on the latched key when every line reads high.
   function automatic display_type keypad_step(input logic [KEY_W-1:0] lines);
      display_type res;
      int unsigned mv;
      key_code_type released;
      logic strobe;
      released = KEY_NONE;
      strobe   = 1'b0;
      if (lines != LINES_IDLE) begin
         run_count = run_count + 1'b1;   // wraps at 16 when the threshold was passed
      end else begin
         run_count = '0;
      end
      if (run_count == debounce_cfg) begin
         run_count = '0;
         key_armed = 1'b1;
         case (lines)
            LINES_S1: held_key = KEY_UP;
            LINES_S5: held_key = KEY_DOWN;
            LINES_K3: held_key = KEY_AUX3;
            LINES_K4: held_key = KEY_AUX4;
            default: ;                   // multi-key: keep the earlier key
         endcase
      end
      if (key_armed && lines == LINES_IDLE) begin
         key_armed = 1'b0;
         released  = held_key;
         if (released == KEY_UP) begin
            setpoint_code = setpoint_code + 1'b1;
            strobe = 1'b1;
         end else if (released == KEY_DOWN) begin
            setpoint_code = setpoint_code - 1'b1;
            strobe = 1'b1;
         end
      end
      // Divide first, then scale; clamp anything a too-large reference would give
      mv = (32'(vref_cfg) / CODE_FULL_SCALE) * 32'(setpoint_code);
      if (mv > 32'(MV_MAX)) begin
         mv = 32'(MV_MAX);
      end
      res.dac_code        = setpoint_code;
      res.dac_write       = strobe;
      res.released_key    = released;
      res.digit_thousands = (mv >= 1000) ? DIGIT_W'(mv / 1000) : BLANK_DIGIT;
      res.digit_hundreds  = (mv >= 100) ? DIGIT_W'((mv % 1000) / 100) : BLANK_DIGIT;
      res.digit_tens      = (mv >= 10) ? DIGIT_W'((mv % 100) / 10) : BLANK_DIGIT;
      res.digit_ones      = DIGIT_W'(mv % 10);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // One register access: setup cycle, then access cycle until pready
   task automatic csr_xfer(input logic wr, input logic idx, input logic [CSR_DATA_W-1:0] wdata,
                           output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write a register, mirror it in the predictor, and read it back
   task automatic csr_set(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] want;
      csr_xfer(1'b1, idx, value, readback);
      if (idx == REG_VREF) begin
         vref_cfg = VREF_W'(value);
         want = 32'(vref_cfg);
      end else begin
         debounce_cfg = RUN_W'(value);
         want = 32'(debounce_cfg);
      end
      csr_xfer(1'b0, idx, '0, readback);
      check_field((idx == REG_VREF) ? "vref_mv" : "debounce_count", want, readback);
   endtask

   task automatic push_lines(input logic [KEY_W-1:0] lines, input int unsigned count);
      repeat (count) begin
         pending_lines.push_back(lines);
         pushed_items++;
      end
   endtask

   // Mostly clean keystrokes with bounce ahead of them; the rest noise or cut-short presses
   task automatic push_random_stroke();
      logic [KEY_W-1:0] key;
      int unsigned      len;
      int unsigned      pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: key = LINES_S1;
            4, 5, 6, 7: key = LINES_S5;
            8:          key = LINES_K3;
            default:    key = LINES_K4;
         endcase
         repeat ($urandom_range(0, 2)) push_lines(KEY_W'($urandom_range(0, 15)), 1);
         len = debounce_cfg + $urandom_range(0, 3);
         push_lines(key, (len == 0) ? 1 : len);
         push_lines(LINES_IDLE, $urandom_range(1, 3));
      end else if (pick < 9) begin
         repeat ($urandom_range(1, 4)) push_lines(KEY_W'($urandom_range(0, 15)), 1);
      end else begin
         push_lines(KEY_W'($urandom_range(0, 14)), (debounce_cfg > 1) ? debounce_cfg - 1 : 1);
         push_lines(LINES_IDLE, 1);
      end
   endtask

   // Hold the sender until every request is in and every result is out, then let the
   // pipeline settle before anything touches the registers.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_lines.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: hold a stalled request, otherwise wait out the drawn gap and
   // offer the next queued sample. Assign req_valid once per step so a back-to-back
   // request never sees a low-then-high pair of updates.
   always @(negedge clock) begin : drive_requests
      logic             next_valid;
      logic [KEY_W-1:0] next_lines;
      next_valid = req_valid;
      next_lines = req_key_lines;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_taken) begin
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
            end else if (pending_lines.size() != 0) begin
               next_valid = 1'b1;
               next_lines = pending_lines.pop_front();
               req_gap <= gaps_on ? $urandom_range(0, 3) : 0;
            end
         end
      end
      req_valid     <= next_valid;
      req_key_lines <= next_lines;
   end

   // Result receiver: stall for a drawn pause after each taken result; on request
   // hold off for a long stretch so the pipeline backs up into the input.
   always @(negedge clock) begin : drive_stall
      int unsigned pause;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (rsp_taken) begin
         pause = gaps_on ? $urandom_range(0, 3) : 0;
         rsp_gap   <= pause;
         rsp_stall <= (pause != 0);
      end else if (rsp_gap != 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_stall <= (rsp_gap > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on every accepted request, compare every accepted result
   // with the oldest prediction, field by field.
   always @(posedge clock) begin : check_results
      display_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            expected_q.push_back(keypad_step(req_key_lines));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result with no request outstanding: dac_code %0d", rsp_dac_code);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("dac_code", 32'(want.dac_code), 32'(rsp_dac_code));
               check_field("dac_write", 32'(want.dac_write), 32'(rsp_dac_write));
               check_field("released_key", 32'(want.released_key), 32'(rsp_released_key));
               check_field("digit_thousands", 32'(want.digit_thousands),
                           32'(rsp_digit_thousands));
               check_field("digit_hundreds", 32'(want.digit_hundreds), 32'(rsp_digit_hundreds));
               check_field("digit_tens", 32'(want.digit_tens), 32'(rsp_digit_tens));
               check_field("digit_ones", 32'(want.digit_ones), 32'(rsp_digit_ones));
            end
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] readback;
      int unsigned           target;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values of both registers, then a short press that must not qualify
      // followed by a full one at the default threshold of five samples.
      csr_xfer(1'b0, REG_VREF, '0, readback);
      check_field("vref_mv", 32'(VREF_RESET), readback);
      csr_xfer(1'b0, REG_DEBOUNCE, '0, readback);
      check_field("debounce_count", 32'(DEBOUNCE_RESET), readback);
      push_lines(LINES_S1, 4);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_S1, 5);
      push_lines(LINES_IDLE, 2);
      wait_idle();

      // Top of the reference range with a one-sample threshold: idle, nothing armed,
      // a multi-key press that releases the key still latched, up and down, the two
      // unused keys, a long hold, and a multi-key press that keeps the earlier key.
      csr_set(REG_VREF, 10199);
      csr_set(REG_DEBOUNCE, 1);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_ALL_DOWN, 1);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_S1, 1);
      push_lines(LINES_IDLE, 1);
      repeat (3) begin
         push_lines(LINES_S5, 1);
         push_lines(LINES_IDLE, 1);
      end
      push_lines(LINES_S1, 1);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_K3, 1);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_K4, 1);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_S1, 3);
      push_lines(LINES_IDLE, 1);
      push_lines(LINES_TWO_KEYS, 1);
      push_lines(LINES_IDLE, 1);
      wait_idle();

      // Lower the threshold under a running count: leave a press half counted at the
      // widest threshold, drop it to three, and let the counter wrap before it matches.
      csr_set(REG_VREF, 0);
      csr_set(REG_DEBOUNCE, 15);
      push_lines(LINES_ALL_DOWN, 8);
      wait_idle();
      csr_set(REG_DEBOUNCE, 3);
      push_lines(LINES_S1, 12);
      push_lines(LINES_IDLE, 1);
      wait_idle();

      // Random phases, each at its own setting. Phase 1 holds the receiver off for a
      // long stretch; phase 2 runs with no idling on either side.
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               csr_set(REG_VREF, VREF_RESET_VAL);
               csr_set(REG_DEBOUNCE, 5);
            end
            1: begin
               csr_set(REG_VREF, 10199);
               csr_set(REG_DEBOUNCE, 1);
            end
            2: begin
               csr_set(REG_VREF, 0);
               csr_set(REG_DEBOUNCE, 2);
            end
            3: begin
               csr_set(REG_VREF, VREF_MAX);
               csr_set(REG_DEBOUNCE, 3);
            end
            4: begin
               csr_set(REG_VREF, 255);
               csr_set(REG_DEBOUNCE, 15);
            end
            5: begin
               csr_set(REG_VREF, 9000);
               csr_set(REG_DEBOUNCE, 0);
            end
            default: begin
               csr_set(REG_VREF, $urandom_range(0, VREF_MAX));
               csr_set(REG_DEBOUNCE, $urandom_range(0, 15));
            end
         endcase
         gaps_on = (p != 2);
         if (p == 1) begin
            hold_asked++;
         end
         target = pushed_items + PHASE_ITEMS;
         while (pushed_items < target) begin
            push_random_stroke();
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Drop the run if it hangs; the slowest legal run is far shorter.
   initial begin : watchdog
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/dkds_pkg.sv
sv/dkds_csr.sv
sv/dkds_key_ctrl.sv
sv/dkds_digits.sv
sv/debounced_keypad_dac_setpoint.sv
sv/dkds_checker.sv
tb/sv/testbench.sv
